// ===== design/mm3_pkg.sv =====
// ----------------------------------------------------------------------------
// mm3_pkg
// Shared types, constants and helpers for the MurmurHash3 x64_128 hash block.
// ----------------------------------------------------------------------------
`default_nettype none

package mm3_pkg;

    localparam int MAX_BYTES = 4096;
    localparam int LEN_W     = $clog2(MAX_BYTES + 1);
    localparam int PC_W      = 5;

    localparam logic [63:0] K_C1   = 64'd9782798678568883157;
    localparam logic [63:0] K_C2   = 64'd5545529020109919103;
    localparam logic [63:0] K_F1   = 64'd18397679294719823053;
    localparam logic [63:0] K_F2   = 64'd14181476777654086739;
    localparam logic [63:0] K_ADD1 = 64'd1390208809;
    localparam logic [63:0] K_ADD2 = 64'd944331445;
    localparam logic [31:0] SEED_RESET = 32'hdeadb0d7;

    typedef struct packed {
        logic [63:0] word_low;
        logic [63:0] word_high;
        logic [4:0]  byte_count;
        logic        last;
    } t_in_item;

    typedef struct packed {
        logic [63:0] hash_value;
        logic        overflowed;
    } t_out_item;

    // One step of the per-item sequence
    typedef enum logic [4:0] {
        U_K1A, U_K1B, U_XOR1, U_MIX1A, U_MIX1B,
        U_K2A, U_K2B, U_XOR2, U_MIX2A, U_MIX2B,
        U_FINLEN, U_ADD12, U_ADD21,
        U_FM1A, U_FM1B, U_XSH1,
        U_FM2A, U_FM2B, U_XSH2,
        U_EMIT
    } t_uop;

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_WAIT
    } t_state;

    typedef enum logic [1:0] {
        DST_K,
        DST_H1,
        DST_H2
    } t_dst;

    typedef struct packed {
        logic load;
        logic exec;
        t_uop uop;
    } t_cmd;

    typedef struct packed {
        logic in_drop;
        logic mul_done;
        logic full;
        logic last;
        logic out_free;
    } t_status;

    localparam logic [PC_W-1:0] PC_K2A = PC_W'(5);
    localparam logic [PC_W-1:0] PC_FIN = PC_W'(10);

    function automatic t_uop uop_at(input logic [PC_W-1:0] pc);
        t_uop u;
        unique case (pc)
            PC_W'(0):  u = U_K1A;
            PC_W'(1):  u = U_K1B;
            PC_W'(2):  u = U_XOR1;
            PC_W'(3):  u = U_MIX1A;
            PC_W'(4):  u = U_MIX1B;
            PC_W'(5):  u = U_K2A;
            PC_W'(6):  u = U_K2B;
            PC_W'(7):  u = U_XOR2;
            PC_W'(8):  u = U_MIX2A;
            PC_W'(9):  u = U_MIX2B;
            PC_W'(10): u = U_FINLEN;
            PC_W'(11): u = U_ADD12;
            PC_W'(12): u = U_ADD21;
            PC_W'(13): u = U_FM1A;
            PC_W'(14): u = U_FM1B;
            PC_W'(15): u = U_XSH1;
            PC_W'(16): u = U_FM2A;
            PC_W'(17): u = U_FM2B;
            PC_W'(18): u = U_XSH2;
            PC_W'(19): u = U_ADD12;
            PC_W'(20): u = U_ADD21;
            default:   u = U_EMIT;
        endcase
        return u;
    endfunction

    function automatic logic is_mul(input t_uop u);
        return (u == U_K1A) || (u == U_K1B) || (u == U_K2A) || (u == U_K2B) ||
               (u == U_FM1A) || (u == U_FM1B) || (u == U_FM2A) || (u == U_FM2B);
    endfunction

    function automatic logic [63:0] rotl64(input logic [63:0] v, input int unsigned r);
        return (v << r) | (v >> (64 - r));
    endfunction

endpackage

`default_nettype wire

// ===== design/mm3_mul.sv =====
// ----------------------------------------------------------------------------
// mm3_mul
// 64 x 64 multiply modulo 2^64 from three 32 x 32 partial products, one a cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module mm3_mul (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic [63:0] i_a,
    input  wire logic [63:0] i_b,
    output logic             o_done,
    output logic [63:0]      o_product
);

    logic [63:0] r_a;
    logic [63:0] r_b;
    logic [63:0] r_acc;
    logic [1:0]  r_phase;
    logic        r_busy;
    logic        r_done;

    logic [31:0] pa;
    logic [31:0] pb;
    logic [63:0] pp;

    // low x low, low x high, high x low; the high x high term falls off the top
    always_comb begin
        case (r_phase)
            2'd0: begin
                pa = r_a[31:0];
                pb = r_b[31:0];
            end
            2'd1: begin
                pa = r_a[31:0];
                pb = r_b[63:32];
            end
            default: begin
                pa = r_a[63:32];
                pb = r_b[31:0];
            end
        endcase
        pp = pa * pb;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_done  <= 1'b0;
            r_phase <= 2'd0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy  <= 1'b1;
                r_phase <= 2'd0;
            end else if (r_busy) begin
                r_phase <= r_phase + 2'd1;
                if (r_phase == 2'd2) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a <= i_a;
            r_b <= i_b;
        end else if (r_busy) begin
            if (r_phase == 2'd0) begin
                r_acc <= pp;
            end else begin
                r_acc[63:32] <= r_acc[63:32] + pp[31:0];
            end
        end
    end

    assign o_done    = r_done;
    assign o_product = r_acc;

endmodule

`default_nettype wire

// ===== design/mm3_dp.sv =====
// ----------------------------------------------------------------------------
// mm3_dp
// Datapath: block capture, hash lanes, length, seed and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module mm3_dp (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cfg_we,
    input  wire logic [31:0]       i_cfg_wdata,
    input  wire mm3_pkg::t_in_item i_in_data,
    input  wire mm3_pkg::t_cmd     i_cmd,
    input  wire logic              i_out_ready,
    output mm3_pkg::t_status       o_status,
    output logic                   o_out_valid,
    output mm3_pkg::t_out_item     o_out_data
);

    logic [31:0]               r_seed;
    logic [63:0]               r_h1;
    logic [63:0]               r_h2;
    logic [63:0]               r_k;
    logic [63:0]               r_w0;
    logic [63:0]               r_w1;
    logic [mm3_pkg::LEN_W-1:0] r_len;
    logic                      r_open;
    logic                      r_full;
    logic                      r_last;
    mm3_pkg::t_dst             r_dst;
    mm3_pkg::t_out_item        r_out;
    logic                      r_out_valid;

    logic [4:0]                cnt;
    logic [127:0]              blk_bytes;
    logic [127:0]              masked;
    logic [mm3_pkg::LEN_W:0]   len_sum;
    logic [mm3_pkg::LEN_W-1:0] len_new;
    logic                      drop;
    logic                      mul_start;
    logic [63:0]               mul_a;
    logic [63:0]               mul_b;
    logic                      mul_done;
    logic [63:0]               mul_p;
    mm3_pkg::t_dst             dst;
    logic [63:0]               h1x;
    logic [63:0]               h2x;
    logic [63:0]               len64;
    logic                      ovf;
    logic                      out_free;

    assign blk_bytes = {i_in_data.word_high, i_in_data.word_low};

    // clamp the count, zero the bytes beyond it
    always_comb begin
        cnt = (i_in_data.byte_count > 5'd16) ? 5'd16 : i_in_data.byte_count;
        for (int i = 0; i < 16; i++) begin
            masked[8*i +: 8] = (5'(i) < cnt) ? blk_bytes[8*i +: 8] : 8'd0;
        end
        drop    = !i_in_data.last && (cnt != 5'd16);
        len_sum = (r_open ? {1'b0, r_len} : '0) + (mm3_pkg::LEN_W + 1)'(cnt);
        len_new = (len_sum > (mm3_pkg::LEN_W + 1)'(mm3_pkg::MAX_BYTES)) ?
                  mm3_pkg::LEN_W'(mm3_pkg::MAX_BYTES) : len_sum[mm3_pkg::LEN_W-1:0];
    end

    assign h1x      = r_h1 ^ (r_h1 >> 33);
    assign h2x      = r_h2 ^ (r_h2 >> 33);
    assign len64    = 64'(r_len);
    assign ovf      = (r_len == mm3_pkg::LEN_W'(mm3_pkg::MAX_BYTES));
    assign out_free = !r_out_valid || i_out_ready;

    // multiplier operands and destination
    always_comb begin
        mul_a = r_w0;
        mul_b = mm3_pkg::K_C1;
        dst   = mm3_pkg::DST_K;
        case (i_cmd.uop)
            mm3_pkg::U_K1A: begin
                mul_a = r_w0;
                mul_b = mm3_pkg::K_C1;
            end
            mm3_pkg::U_K1B: begin
                mul_a = mm3_pkg::rotl64(r_k, 31);
                mul_b = mm3_pkg::K_C2;
            end
            mm3_pkg::U_K2A: begin
                mul_a = r_w1;
                mul_b = mm3_pkg::K_C2;
            end
            mm3_pkg::U_K2B: begin
                mul_a = mm3_pkg::rotl64(r_k, 33);
                mul_b = mm3_pkg::K_C1;
            end
            mm3_pkg::U_FM1A: begin
                mul_a = h1x;
                mul_b = mm3_pkg::K_F1;
                dst   = mm3_pkg::DST_H1;
            end
            mm3_pkg::U_FM1B: begin
                mul_a = h1x;
                mul_b = mm3_pkg::K_F2;
                dst   = mm3_pkg::DST_H1;
            end
            mm3_pkg::U_FM2A: begin
                mul_a = h2x;
                mul_b = mm3_pkg::K_F1;
                dst   = mm3_pkg::DST_H2;
            end
            mm3_pkg::U_FM2B: begin
                mul_a = h2x;
                mul_b = mm3_pkg::K_F2;
                dst   = mm3_pkg::DST_H2;
            end
            default: begin
                mul_a = r_w0;
                mul_b = mm3_pkg::K_C1;
                dst   = mm3_pkg::DST_K;
            end
        endcase
        mul_start = i_cmd.exec && mm3_pkg::is_mul(i_cmd.uop);
    end

    mm3_mul u_mul (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (mul_start),
        .i_a       (mul_a),
        .i_b       (mul_b),
        .o_done    (mul_done),
        .o_product (mul_p)
    );

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed      <= mm3_pkg::SEED_RESET;
            r_open      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_seed <= i_cfg_wdata;
            end
            if (i_cmd.load && !drop) begin
                r_open <= 1'b1;
            end
            if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cmd.exec && (i_cmd.uop == mm3_pkg::U_EMIT)) begin
                r_out_valid <= 1'b1;
                r_open      <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.load && !drop) begin
            r_w0   <= masked[63:0];
            r_w1   <= masked[127:64];
            r_full <= (cnt == 5'd16);
            r_last <= i_in_data.last;
            r_len  <= len_new;
            if (!r_open) begin
                r_h1 <= 64'(r_seed);
                r_h2 <= 64'(r_seed);
            end
        end
        if (mul_start) begin
            r_dst <= dst;
        end
        if (mul_done) begin
            case (r_dst)
                mm3_pkg::DST_H1: r_h1 <= mul_p;
                mm3_pkg::DST_H2: r_h2 <= mul_p;
                default:         r_k  <= mul_p;
            endcase
        end
        if (i_cmd.exec) begin
            case (i_cmd.uop)
                mm3_pkg::U_XOR1:   r_h1 <= r_h1 ^ r_k;
                mm3_pkg::U_MIX1A:  r_h1 <= mm3_pkg::rotl64(r_h1, 27) + r_h2;
                mm3_pkg::U_MIX1B:  r_h1 <= (r_h1 << 2) + r_h1 + mm3_pkg::K_ADD1;
                mm3_pkg::U_XOR2:   r_h2 <= r_h2 ^ r_k;
                mm3_pkg::U_MIX2A:  r_h2 <= mm3_pkg::rotl64(r_h2, 31) + r_h1;
                mm3_pkg::U_MIX2B:  r_h2 <= (r_h2 << 2) + r_h2 + mm3_pkg::K_ADD2;
                mm3_pkg::U_FINLEN: begin
                    r_h1 <= r_h1 ^ len64;
                    r_h2 <= r_h2 ^ len64;
                end
                mm3_pkg::U_ADD12:  r_h1 <= r_h1 + r_h2;
                mm3_pkg::U_ADD21:  r_h2 <= r_h2 + r_h1;
                mm3_pkg::U_XSH1:   r_h1 <= h1x;
                mm3_pkg::U_XSH2:   r_h2 <= h2x;
                mm3_pkg::U_EMIT: begin
                    r_out.hash_value <= ovf ? 64'd0 : r_h2;
                    r_out.overflowed <= ovf;
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        o_status.in_drop  = drop;
        o_status.mul_done = mul_done;
        o_status.full     = r_full;
        o_status.last     = r_last;
        o_status.out_free = out_free;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

`default_nettype wire

// ===== design/mm3_ctrl.sv =====
// ----------------------------------------------------------------------------
// mm3_ctrl
// Controller: accepts blocks and steps the datapath through the hash sequence.
// ----------------------------------------------------------------------------
`default_nettype none

module mm3_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    input  wire mm3_pkg::t_status i_status,
    output logic                  o_in_ready,
    output mm3_pkg::t_cmd         o_cmd
);

    mm3_pkg::t_state              r_state;
    mm3_pkg::t_state              n_state;
    logic [mm3_pkg::PC_W-1:0]     r_pc;
    logic [mm3_pkg::PC_W-1:0]     n_pc;
    mm3_pkg::t_uop                uop;

    assign uop = mm3_pkg::uop_at(r_pc);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mm3_pkg::S_IDLE;
            r_pc    <= '0;
        end else begin
            r_state <= n_state;
            r_pc    <= n_pc;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        n_pc    = r_pc;
        unique case (r_state)
            mm3_pkg::S_IDLE: begin
                if (i_in_valid && !i_status.in_drop) begin
                    n_state = mm3_pkg::S_RUN;
                    n_pc    = '0;
                end
            end
            mm3_pkg::S_RUN: begin
                if (mm3_pkg::is_mul(uop)) begin
                    n_state = mm3_pkg::S_WAIT;
                end else if (uop == mm3_pkg::U_EMIT) begin
                    if (i_status.out_free) begin
                        n_state = mm3_pkg::S_IDLE;
                    end
                end else if ((uop == mm3_pkg::U_XOR1) && !i_status.full) begin
                    n_pc = mm3_pkg::PC_K2A;
                end else if (((uop == mm3_pkg::U_XOR2) && !i_status.full) ||
                             (uop == mm3_pkg::U_MIX2B)) begin
                    if (i_status.last) begin
                        n_pc = mm3_pkg::PC_FIN;
                    end else begin
                        n_state = mm3_pkg::S_IDLE;
                    end
                end else begin
                    n_pc = r_pc + mm3_pkg::PC_W'(1);
                end
            end
            mm3_pkg::S_WAIT: begin
                if (i_status.mul_done) begin
                    n_state = mm3_pkg::S_RUN;
                    n_pc    = r_pc + mm3_pkg::PC_W'(1);
                end
            end
            default: begin
                n_state = mm3_pkg::S_IDLE;
            end
        endcase
    end

    // outputs
    always_comb begin
        o_in_ready = 1'b0;
        o_cmd.load = 1'b0;
        o_cmd.exec = 1'b0;
        o_cmd.uop  = uop;
        unique case (r_state)
            mm3_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            mm3_pkg::S_RUN: begin
                o_cmd.exec = (uop != mm3_pkg::U_EMIT) || i_status.out_free;
            end
            default: begin
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== design/murmur3_x64_128_hash_top.sv =====
// ----------------------------------------------------------------------------
// murmur3_x64_128_hash_top
// MurmurHash3 x64_128 over 16-byte blocks; emits the second digest half.
// ----------------------------------------------------------------------------
// Input: a new block is taken only in idle, once the previous block is done; a
//   dropped block is taken and discarded without starting the sequence.
// Multiplies: the eight 64-bit multiplies all run in turn on the one shared
//   32 x 32 multiplier.
// Reset: synchronous, active low; seed returns to 0xdeadb0d7, no message open,
//   result register empty.
// ----------------------------------------------------------------------------
`default_nettype none

module murmur3_x64_128_hash_top (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    // seed register write
    input  wire logic               i_cfg_we,
    input  wire logic [31:0]        i_cfg_wdata,
    // block input channel
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire mm3_pkg::t_in_item  i_in_data,
    // result channel
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output mm3_pkg::t_out_item      o_out_data
);

    mm3_pkg::t_cmd    cmd;
    mm3_pkg::t_status status;

    // Controller: takes one block at a time, drops a partial block that is not
    // last, and walks the datapath through body round, tail, finalisation.
    mm3_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_status   (status),
        .o_in_ready (o_in_ready),
        .o_cmd      (cmd)
    );

    // Datapath: hold lanes, length and seed; the result register parts the
    // output side so the next message can start while a result waits.
    mm3_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_data   (i_in_data),
        .i_cmd       (cmd),
        .i_out_ready (i_out_ready),
        .o_status    (status),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

endmodule

`default_nettype wire
